// ----- rtl/core/smd_pkg.sv -----
`timescale 1ns / 1ps

package smd_pkg;

	// Default sample width, Q2.F with F = width - 3
	localparam int SampleWidthDef = 16;

	// Ideal coordinates held at 21 fraction bits
	localparam int FullFrac = 21;
	localparam int OneHi    = 2097152;
	localparam int QpskHi   = 1482896;
	localparam int Psk8Hi   = 1482910;

	// Widest QAM axis and its level index width
	localparam int MaxLevels = 16;
	localparam int LevelBits = 4;

	// Mode register codes
	localparam logic [2:0] MODE_BPSK   = 3'd0;
	localparam logic [2:0] MODE_QPSK   = 3'd1;
	localparam logic [2:0] MODE_PSK8   = 3'd2;
	localparam logic [2:0] MODE_QAM16  = 3'd3;
	localparam logic [2:0] MODE_QAM64  = 3'd4;
	localparam logic [2:0] MODE_QAM256 = 3'd5;

	// Operation codes
	localparam logic OP_MOD   = 1'b0;
	localparam logic OP_DEMOD = 1'b1;

	// Control that travels with each beat
	typedef struct packed {
		logic       op;
		logic [2:0] mode;
	} meta_t;

	// Round a Q2.21 magnitude to the output grid, half away from zero
	function automatic int to_out(int mag, bit neg, int sw);
		int sh;
		int r;
		sh = FullFrac - (sw - 3);
		r  = mag;
		if (sh > 0) begin
			r = (mag + (1 << (sh - 1))) >>> sh;
		end
		return neg ? -r : r;
	endfunction

	// Positive QAM level magnitudes per mode
	function automatic int lvl_mag(logic [2:0] m, int t);
		int r;
		r = 0;
		case (m)
			MODE_QAM16: begin
				case (t)
					0: r = 663173;
					default: r = 1989519;
				endcase
			end
			MODE_QAM64: begin
				case (t)
					0: r = 323598;
					1: r = 970793;
					2: r = 1617988;
					default: r = 2265183;
				endcase
			end
			MODE_QAM256: begin
				case (t)
					0: r = 160844;
					1: r = 482533;
					2: r = 804221;
					3: r = 1125910;
					4: r = 1447598;
					5: r = 1769286;
					6: r = 2090975;
					default: r = 2412663;
				endcase
			end
			default: r = 0;
		endcase
		return r;
	endfunction

	// Levels per axis, zero for the PSK modes
	function automatic int num_levels(logic [2:0] m);
		int r;
		case (m)
			MODE_QAM16:  r = 4;
			MODE_QAM64:  r = 8;
			MODE_QAM256: r = 16;
			default:     r = 0;
		endcase
		return r;
	endfunction

	// Level j counted from the most negative
	function automatic int qam_level(logic [2:0] m, int j, int sw);
		int half;
		half = num_levels(m) >> 1;
		if (j >= half) begin
			return to_out(lvl_mag(m, j - half), 1'b0, sw);
		end
		return to_out(lvl_mag(m, half - 1 - j), 1'b1, sw);
	endfunction

	function automatic int order_of(logic [2:0] m);
		int r;
		case (m)
			MODE_BPSK:   r = 2;
			MODE_PSK8:   r = 8;
			MODE_QAM16:  r = 16;
			MODE_QAM64:  r = 64;
			MODE_QAM256: r = 256;
			default:     r = 4;
		endcase
		return r;
	endfunction

	// 8PSK coordinate code: 2 is one, 1 is the diagonal, sign for side
	function automatic int psk8_val(int code, int sw);
		int a;
		int mag;
		a   = (code < 0) ? -code : code;
		mag = (a == 2) ? OneHi : ((a == 1) ? Psk8Hi : 0);
		return to_out(mag, code < 0, sw);
	endfunction

	function automatic int psk8_ci(logic [2:0] k);
		int r;
		case (k)
			3'd0: r = 2;
			3'd1: r = 1;
			3'd2: r = 0;
			3'd3: r = -1;
			3'd4: r = -2;
			3'd5: r = -1;
			3'd6: r = 0;
			default: r = 1;
		endcase
		return r;
	endfunction

	function automatic int psk8_cq(logic [2:0] k);
		int r;
		case (k)
			3'd0: r = 0;
			3'd1: r = 1;
			3'd2: r = 2;
			3'd3: r = 1;
			3'd4: r = 0;
			3'd5: r = -1;
			3'd6: r = -2;
			default: r = -1;
		endcase
		return r;
	endfunction

	// In-phase coordinate of a point
	function automatic int map_i(logic [2:0] m, logic [7:0] idx, int sw);
		int r;
		case (m)
			MODE_BPSK:   r = to_out(OneHi, idx[0], sw);
			MODE_PSK8:   r = psk8_val(psk8_ci(idx[2:0]), sw);
			MODE_QAM16:  r = qam_level(m, int'(idx[3:2]), sw);
			MODE_QAM64:  r = qam_level(m, int'(idx[5:3]), sw);
			MODE_QAM256: r = qam_level(m, int'(idx[7:4]), sw);
			default:     r = to_out(QpskHi, idx[1:0] == 2'd1 || idx[1:0] == 2'd2, sw);
		endcase
		return r;
	endfunction

	// Quadrature coordinate of a point
	function automatic int map_q(logic [2:0] m, logic [7:0] idx, int sw);
		int r;
		case (m)
			MODE_BPSK:   r = 0;
			MODE_PSK8:   r = psk8_val(psk8_cq(idx[2:0]), sw);
			MODE_QAM16:  r = qam_level(m, int'(idx[1:0]), sw);
			MODE_QAM64:  r = qam_level(m, int'(idx[2:0]), sw);
			MODE_QAM256: r = qam_level(m, int'(idx[3:0]), sw);
			default:     r = to_out(QpskHi, idx[1], sw);
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/smd_slice.sv -----
`timescale 1ns / 1ps

// QAM axis slicer: nearest level, lower level wins a tie
module smd_slice #(
	parameter int SAMPLE_WIDTH = smd_pkg::SampleWidthDef
) (
	input  logic                                  clk,
	input  logic [2:0]                            mode,
	input  logic signed [SAMPLE_WIDTH-1:0]        s,
	output logic [smd_pkg::LevelBits-1:0]         level_s3
);

	localparam int W2 = SAMPLE_WIDTH + 2;
	localparam int NumMid = smd_pkg::MaxLevels - 1;

	logic signed [W2-1:0] s_x2;
	logic [NumMid-1:0]    gt;
	logic [NumMid-1:0]    gt_s2;
	logic [smd_pkg::LevelBits-1:0] cnt;

	assign s_x2 = W2'(s) <<< 1;

	// Compare twice the sample against each pair sum of adjacent levels
	always_comb begin
		int thr;
		for (int k = 0; k < NumMid; k++) begin
			thr = smd_pkg::qam_level(mode, k, SAMPLE_WIDTH)
				+ smd_pkg::qam_level(mode, k + 1, SAMPLE_WIDTH);
			gt[k] = (k < smd_pkg::num_levels(mode) - 1) && (s_x2 > W2'(thr));
		end
	end

	// Count thresholds passed
	always_comb begin
		cnt = '0;
		for (int k = 0; k < NumMid; k++) begin
			cnt = cnt + smd_pkg::LevelBits'(gt_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		gt_s2    <= gt;
		level_s3 <= cnt;
	end

endmodule

// ----- rtl/core/smd_psk8.sv -----
`timescale 1ns / 1ps

// 8PSK nearest point: |c|^2 - 2<s,c> per point, then a min tree
module smd_psk8 #(
	parameter int SAMPLE_WIDTH = smd_pkg::SampleWidthDef
) (
	input  logic                           clk,
	input  logic signed [SAMPLE_WIDTH-1:0] si,
	input  logic signed [SAMPLE_WIDTH-1:0] sq,
	output logic [2:0]                     index
);

	localparam int EW = 2 * SAMPLE_WIDTH + 2;
	localparam int A  = smd_pkg::to_out(smd_pkg::OneHi, 1'b0, SAMPLE_WIDTH);
	localparam int B  = smd_pkg::to_out(smd_pkg::Psk8Hi, 1'b0, SAMPLE_WIDTH);
	localparam longint AAL  = longint'(A) * longint'(A);
	localparam longint BB2L = 2 * longint'(B) * longint'(B);
	localparam logic signed [EW-1:0] CA  = EW'(A);
	localparam logic signed [EW-1:0] CB  = EW'(B);
	localparam logic signed [EW-1:0] AA  = EW'(AAL);
	localparam logic signed [EW-1:0] BB2 = EW'(BB2L);

	logic signed [EW-1:0] pai_s2, pbi_s2, paq_s2, pbq_s2;
	logic signed [EW-1:0] e [8];
	logic signed [EW-1:0] e_s3 [8];
	logic signed [EW-1:0] v_s4 [4];
	logic [2:0]           k_s4 [4];
	logic signed [EW-1:0] va, vb;
	logic [2:0]           ka, kb;

	// Scale the sample by both coordinate magnitudes
	always_ff @(posedge clk) begin
		pai_s2 <= EW'(si) * CA;
		pbi_s2 <= EW'(si) * CB;
		paq_s2 <= EW'(sq) * CA;
		pbq_s2 <= EW'(sq) * CB;
	end

	// Distance minus the common |s|^2 term
	always_comb begin
		e[0] = AA - (pai_s2 <<< 1);
		e[1] = BB2 - ((pbi_s2 + pbq_s2) <<< 1);
		e[2] = AA - (paq_s2 <<< 1);
		e[3] = BB2 - ((pbq_s2 - pbi_s2) <<< 1);
		e[4] = AA + (pai_s2 <<< 1);
		e[5] = BB2 + ((pbi_s2 + pbq_s2) <<< 1);
		e[6] = AA + (paq_s2 <<< 1);
		e[7] = BB2 - ((pbi_s2 - pbq_s2) <<< 1);
	end

	// First min level, lower index kept on a tie
	always_ff @(posedge clk) begin
		e_s3 <= e;
		for (int p = 0; p < 4; p++) begin
			if (e_s3[2*p+1] < e_s3[2*p]) begin
				v_s4[p] <= e_s3[2*p+1];
				k_s4[p] <= 3'(2*p+1);
			end else begin
				v_s4[p] <= e_s3[2*p];
				k_s4[p] <= 3'(2*p);
			end
		end
	end

	// Final two levels
	always_comb begin
		va = v_s4[0];
		ka = k_s4[0];
		if (v_s4[1] < v_s4[0]) begin
			va = v_s4[1];
			ka = k_s4[1];
		end
		vb = v_s4[2];
		kb = k_s4[2];
		if (v_s4[3] < v_s4[2]) begin
			vb = v_s4[3];
			kb = k_s4[3];
		end
		index = (vb < va) ? kb : ka;
	end

endmodule

// ----- rtl/core/psk_qam_symbol_mapper_demapper.sv -----
`timescale 1ns / 1ps

// Channel   Signals                                 Beat marker
// config    mode_we, mode_wdata                     mode_we high at the edge
// input     op, symbol_index, sample_i, sample_q    start high, busy low
// result    point_i, point_q, decided_index         done high for one cycle
//
// One beat may enter every cycle; busy stays low. Each result leaves the
// result register behind the 8PSK distance and min pipeline, which sets the depth.
// Reset clears valid bits and sets mode to QPSK. The receiver cannot stall,
// so the pipeline advances every cycle.
module psk_qam_symbol_mapper_demapper #(
	parameter int SAMPLE_WIDTH = smd_pkg::SampleWidthDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic [7:0]                     symbol_index,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_q,
	input  logic                           mode_we,
	input  logic [2:0]                     mode_wdata,
	output logic                           done,
	output logic signed [SAMPLE_WIDTH-1:0] point_i,
	output logic signed [SAMPLE_WIDTH-1:0] point_q,
	output logic [7:0]                     decided_index
);

	localparam int LB = smd_pkg::LevelBits;

	logic [2:0] mode_q;
	logic v_s1, v_s2, v_s3, v_s4, done_q;
	smd_pkg::meta_t meta_s1, meta_s2, meta_s3, meta_s4;
	logic [7:0] idx_s1;
	logic signed [SAMPLE_WIDTH-1:0] si_s1, sq_s1;
	logic signed [SAMPLE_WIDTH-1:0] pi_s2, pi_s3, pi_s4, pq_s2, pq_s3, pq_s4;
	logic [1:0] fast_s2, fast_s3, fast_s4;
	logic [LB-1:0] lvi_s3, lvq_s3, lvi_s4, lvq_s4;
	logic [2:0] psk_idx;
	logic signed [SAMPLE_WIDTH-1:0] map_pi, map_pq;
	logic ni, nq;
	logic [1:0] fast;
	logic [7:0] dec;
	logic signed [SAMPLE_WIDTH-1:0] point_i_q, point_q_q;
	logic [7:0] decided_q;

	assign busy = 1'b0;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= smd_pkg::MODE_QPSK;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	// Capture the beat
	always_ff @(posedge clk) begin
		meta_s1.op   <= op;
		meta_s1.mode <= mode_q;
		idx_s1       <= symbol_index;
		si_s1        <= sample_i;
		sq_s1        <= sample_q;
	end

	// Map the index; out-of-range indexes go to the origin
	always_comb begin
		map_pi = '0;
		map_pq = '0;
		if (int'(idx_s1) < smd_pkg::order_of(meta_s1.mode)) begin
			map_pi = SAMPLE_WIDTH'(smd_pkg::map_i(meta_s1.mode, idx_s1, SAMPLE_WIDTH));
			map_pq = SAMPLE_WIDTH'(smd_pkg::map_q(meta_s1.mode, idx_s1, SAMPLE_WIDTH));
		end
	end

	// BPSK and QPSK decisions by sign, ties to the lowest index
	always_comb begin
		nq = sq_s1[SAMPLE_WIDTH-1];
		ni = si_s1[SAMPLE_WIDTH-1] || (si_s1 == '0 && nq);
		if (meta_s1.mode == smd_pkg::MODE_BPSK) begin
			fast = {1'b0, si_s1[SAMPLE_WIDTH-1]};
		end else begin
			fast = {nq, ni ^ nq};
		end
	end

	smd_slice #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_slice_i (
		.clk      (clk),
		.mode     (meta_s1.mode),
		.s        (si_s1),
		.level_s3 (lvi_s3)
	);

	smd_slice #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_slice_q (
		.clk      (clk),
		.mode     (meta_s1.mode),
		.s        (sq_s1),
		.level_s3 (lvq_s3)
	);

	smd_psk8 #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_psk8 (
		.clk   (clk),
		.si    (si_s1),
		.sq    (sq_s1),
		.index (psk_idx)
	);

	// Advance payload
	always_ff @(posedge clk) begin
		meta_s2 <= meta_s1;
		meta_s3 <= meta_s2;
		meta_s4 <= meta_s3;
		pi_s2   <= map_pi;
		pi_s3   <= pi_s2;
		pi_s4   <= pi_s3;
		pq_s2   <= map_pq;
		pq_s3   <= pq_s2;
		pq_s4   <= pq_s3;
		fast_s2 <= fast;
		fast_s3 <= fast_s2;
		fast_s4 <= fast_s3;
		lvi_s4  <= lvi_s3;
		lvq_s4  <= lvq_s3;
	end

	// Assemble the decision
	always_comb begin
		case (meta_s4.mode)
			smd_pkg::MODE_PSK8:   dec = {5'd0, psk_idx};
			smd_pkg::MODE_QAM16:  dec = {4'd0, lvi_s4[1:0], lvq_s4[1:0]};
			smd_pkg::MODE_QAM64:  dec = {2'd0, lvi_s4[2:0], lvq_s4[2:0]};
			smd_pkg::MODE_QAM256: dec = {lvi_s4, lvq_s4};
			default:              dec = {6'd0, fast_s4};
		endcase
	end

	// Result register
	always_ff @(posedge clk) begin
		if (meta_s4.op == smd_pkg::OP_MOD) begin
			point_i_q <= pi_s4;
			point_q_q <= pq_s4;
			decided_q <= '0;
		end else begin
			point_i_q <= '0;
			point_q_q <= '0;
			decided_q <= dec;
		end
	end

	assign done          = done_q;
	assign point_i       = point_i_q;
	assign point_q       = point_q_q;
	assign decided_index = decided_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |=> done) else $error("result beat dropped");

	a_mod_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		done && decided_index != 8'd0 |-> $past(meta_s4.op) == smd_pkg::OP_DEMOD)
		else $error("index on a modulate beat");

	a_demod_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		done && (point_i != '0 || point_q != '0) |-> $past(meta_s4.op) == smd_pkg::OP_MOD)
		else $error("point on a demodulate beat");

endmodule
